// ===== sv/hs_pkg.sv =====
`default_nettype none
package hs_pkg;

  localparam int KEY_W = 64;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    key_t key_value;
    logic last_item;
  } in_item_t;

  typedef struct packed {
    key_t sorted_key;
    logic last_result;
    logic overflowed;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/hs_ram.sv =====
`default_nettype none
module hs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== sv/heap_sorter.sv =====
// channel  | ports                        | transfer
// ---------+------------------------------+-------------------------------------
// input    | start, busy, in_data         | taken when start is high, busy low
// result   | out_strobe, out_data         | one cycle per result, no back-pressure
//
// each key that fits is stored; the closing key holds busy high until the final result
// each sift runs FETCH, TOP and EVAL for its top and first level, then READ and EVAL per
// further level, as the key memory has registered reads and a single write port
// output runs one result per cycle from the memory's registered read port
// reset is synchronous; the key memory is not cleared, only entries of the set are used
`default_nettype none
module heap_sorter #(
  parameter int DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire hs_pkg::in_item_t in_data,
  output logic                  out_strobe,
  output hs_pkg::out_item_t     out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_TOP   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          extract_r, extract_nxt;
  logic [AW-1:0] bidx_r, bidx_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [AW-1:0] oidx_r, oidx_nxt;
  hs_pkg::key_t  v_r, v_nxt;
  logic          pend_r, pend_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic          pend_ovf_r, pend_ovf_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  hs_pkg::key_t  wdata, rdata_a, rdata_b;

  logic          accept, has_room;
  logic [CW-1:0] n_new;
  logic [IW-1:0] c_l, c_r, len_ext;
  logic          has_l, has_r, pick_r, go_down;
  hs_pkg::key_t  kc;
  logic [IW-1:0] cidx;

  hs_ram #(
    .WIDTH(hs_pkg::KEY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  assign busy     = (state_r != S_LOAD);
  assign accept   = start && !busy;
  assign has_room = (count_r < CW'(DEPTH));
  assign n_new    = has_room ? count_r + CW'(1) : count_r;

  // children of the current node and the larger one, right child on a tie
  assign c_l     = {1'b0, node_r, 1'b1};
  assign c_r     = c_l + IW'(1);
  assign len_ext = IW'(len_r);
  assign has_l   = (c_l < len_ext);
  assign has_r   = (c_r < len_ext);
  assign pick_r  = has_r && !(rdata_b < rdata_a);
  assign kc      = pick_r ? rdata_b : rdata_a;
  assign cidx    = pick_r ? c_r : c_l;
  assign go_down = has_l && (v_r < kc);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    extract_nxt   = extract_r;
    bidx_nxt      = bidx_r;
    node_nxt      = node_r;
    len_nxt       = len_r;
    oidx_nxt      = oidx_r;
    v_nxt         = v_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    pend_ovf_nxt  = pend_ovf_r;
    we            = 1'b0;
    waddr         = count_r[AW-1:0];
    wdata         = in_data.key_value;
    raddr_a       = node_r;
    raddr_b       = len_r[AW-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (has_room) begin
            we        = 1'b1;
            count_nxt = n_new;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            extract_nxt = 1'b0;
            oidx_nxt    = '0;
            len_nxt     = n_new;
            bidx_nxt    = AW'((n_new >> 1) - CW'(1));
            node_nxt    = AW'((n_new >> 1) - CW'(1));
            // a single key is already sorted
            state_nxt   = (n_new == CW'(1)) ? S_OUT : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        raddr_a   = node_r;
        raddr_b   = len_r[AW-1:0];
        state_nxt = S_TOP;
      end
      S_TOP: begin
        // extraction moves the root to the end and sifts the former last entry
        if (extract_r) begin
          v_nxt = rdata_b;
          we    = 1'b1;
          waddr = len_r[AW-1:0];
          wdata = rdata_a;
        end else begin
          v_nxt = rdata_a;
        end
        raddr_a   = c_l[AW-1:0];
        raddr_b   = c_r[AW-1:0];
        state_nxt = S_EVAL;
      end
      S_READ: begin
        raddr_a   = c_l[AW-1:0];
        raddr_b   = c_r[AW-1:0];
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        we    = 1'b1;
        waddr = node_r;
        if (go_down) begin
          wdata     = kc;
          node_nxt  = cidx[AW-1:0];
          state_nxt = S_READ;
        end else begin
          wdata = v_r;
          if (!extract_r) begin
            if (bidx_r == '0) begin
              extract_nxt = 1'b1;
              len_nxt     = count_r - CW'(1);
              node_nxt    = '0;
            end else begin
              bidx_nxt = bidx_r - AW'(1);
              node_nxt = bidx_r - AW'(1);
            end
            state_nxt = S_FETCH;
          end else if (len_r == CW'(1)) begin
            oidx_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            len_nxt   = len_r - CW'(1);
            node_nxt  = '0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_OUT: begin
        raddr_a       = oidx_r;
        pend_nxt      = 1'b1;
        pend_ovf_nxt  = ovf_r;
        pend_last_nxt = (CW'(oidx_r) == count_r - CW'(1));
        if (CW'(oidx_r) == count_r - CW'(1)) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          oidx_nxt = oidx_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      extract_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      extract_r <= extract_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bidx_r      <= bidx_nxt;
    node_r      <= node_nxt;
    len_r       <= len_nxt;
    oidx_r      <= oidx_nxt;
    v_r         <= v_nxt;
    pend_last_r <= pend_last_nxt;
    pend_ovf_r  <= pend_ovf_nxt;
  end

  assign out_strobe = pend_r;

  always_comb begin
    out_data.sorted_key  = rdata_a;
    out_data.last_result = pend_last_r;
    out_data.overflowed  = pend_ovf_r;
  end

endmodule
`default_nettype wire

// ===== sv/hs_checker.sv =====
`default_nettype none
module hs_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire hs_pkg::in_item_t  in_data,
  input wire logic              out_strobe,
  input wire hs_pkg::out_item_t out_data
);

  // results only come out of a sort, never straight from loading
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(rst_n) |-> $past(busy))
    else $error("result without a preceding sort");

  // a sorted run comes out without gaps
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last_result |=> out_strobe)
    else $error("gap inside a sorted run");

  // the final result of a run finds the block ready for the next set
  a_idle_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.last_result |-> !busy)
    else $error("block still busy at the end of a run");

  // a key that does not close the set leaves the block idle and silent
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_data.last_item |=> !busy && !out_strobe)
    else $error("loading a key started work");

  // the overflow flag is the same on every result of a run
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last_result |=>
      out_data.overflowed == $past(out_data.overflowed))
    else $error("overflow flag changed within a run");

endmodule

bind heap_sorter hs_checker u_hs_checker (.*);
`default_nettype wire

// ===== sim/heap_sorter_test.sv =====
`timescale 1ns / 1ps

module heap_sorter_test;

  localparam int SORT_DEPTH  = 64;
  localparam int IDLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 200;
  localparam int RANDOM_KEYS = 250;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  hs_pkg::in_item_t  in_data;
  logic              out_strobe;
  hs_pkg::out_item_t out_data;

  heap_sorter #(.DEPTH(SORT_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  hs_pkg::in_item_t  pending_keys[$];
  hs_pkg::out_item_t sorted_expect[$];

  // shadow of the block's key store for the set being loaded
  hs_pkg::key_t held_keys[SORT_DEPTH];
  int   held_count = 0;
  logic drop_seen  = 1'b0;

  logic in_taken = 1'b0;
  int   gap_left = 0;
  logic calm_stretch = 1'b0;
  int   idle_cycles = 0;

  int keys_taken = 0;
  int results_checked = 0;
  int sets_closed = 0;
  int overflow_sets = 0;
  int largest_set = 0;
  int mismatch_count = 0;

  function automatic void sift_down_heap(input int len, input int top);
    int           node;
    int           child;
    hs_pkg::key_t tmp;
    node = top;
    while (2 * node + 1 < len) begin
      child = 2 * node + 1;
      // ties go to the right child
      if (child + 1 < len && !(held_keys[child + 1] < held_keys[child])) child++;
      if (held_keys[node] < held_keys[child]) begin
        tmp = held_keys[node];
        held_keys[node] = held_keys[child];
        held_keys[child] = tmp;
        node = child;
      end else begin
        break;
      end
    end
  endfunction

  task automatic take_key(input hs_pkg::in_item_t it);
    int                n;
    int                i;
    hs_pkg::key_t      tmp;
    hs_pkg::out_item_t res;
    if (held_count < SORT_DEPTH) begin
      held_keys[held_count] = it.key_value;
      held_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (it.last_item) begin
      n = held_count;
      for (i = n - 1; i >= 0; i--) sift_down_heap(n, i);
      for (i = n - 1; i > 0; i--) begin
        tmp = held_keys[0];
        held_keys[0] = held_keys[i];
        held_keys[i] = tmp;
        sift_down_heap(i, 0);
      end
      for (i = 0; i < n; i++) begin
        res.sorted_key  = held_keys[i];
        res.last_result = (i == n - 1);
        res.overflowed  = drop_seen;
        sorted_expect.push_back(res);
      end
      sets_closed++;
      if (drop_seen) overflow_sets++;
      if (n > largest_set) largest_set = n;
      held_count = 0;
      drop_seen  = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 10) $display("%t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic hs_pkg::key_t rand_key();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      // narrow range to force ties
      1: return hs_pkg::key_t'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, 63'd0};
          1: return {1'b0, {63{1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      3: return {$urandom, 32'd0};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_key(input hs_pkg::key_t k, input logic last);
    hs_pkg::in_item_t it;
    it.key_value = k;
    it.last_item = last;
    pending_keys.push_back(it);
  endtask

  task automatic add_set(input int size);
    int i;
    for (i = 0; i < size; i++) push_key(rand_key(), i == size - 1);
  endtask

  // driver: one transaction at a time from the pending queue
  always @(negedge clk) begin
    logic present;
    present = start;
    if (!rst_n) begin
      present = 1'b0;
    end else begin
      if (start && in_taken) begin
        void'(pending_keys.pop_front());
        present = 1'b0;
        if ($urandom_range(0, 15) == 0) calm_stretch = !calm_stretch;
        gap_left = calm_stretch ? 0 : $urandom_range(0, 3);
      end
      if (!present) begin
        if (gap_left > 0) gap_left--;
        else if (pending_keys.size() > 0) present = 1'b1;
      end
    end
    start <= present;
    if (present) in_data <= pending_keys[0];
  end

  // monitor: predict on accepted keys, check every strobed result
  always @(posedge clk) begin
    hs_pkg::out_item_t got;
    hs_pkg::out_item_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (start && !busy) begin
        take_key(in_data);
        keys_taken++;
        in_taken <= 1'b1;
      end else begin
        in_taken <= 1'b0;
      end
      if (out_strobe) begin
        got = out_data;
        if (sorted_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected result key %h last %b ovf %b",
                                    got.sorted_key, got.last_result, got.overflowed));
        end else begin
          want = sorted_expect.pop_front();
          if (got.sorted_key !== want.sorted_key || got.last_result !== want.last_result ||
              got.overflowed !== want.overflowed)
            report_mismatch($sformatf(
              "result %0d: expected key %h last %b ovf %b, got key %h last %b ovf %b",
              results_checked, want.sorted_key, want.last_result, want.overflowed,
              got.sorted_key, got.last_result, got.overflowed));
        end
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("heap_sorter test failed");
      $finish;
    end
  end

  initial begin
    int random_count;
    int size;
    int i;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;

    // single key set at the top of the range
    push_key({1'b0, {63{1'b1}}}, 1'b1);
    // extremes and signed Q32.32 values around zero
    push_key({1'b1, 63'd0}, 1'b0);
    push_key({1'b0, {63{1'b1}}}, 1'b0);
    push_key(64'sd0, 1'b0);
    push_key(-64'sd1, 1'b0);
    push_key(64'sd1, 1'b0);
    push_key(64'sh0000_0001_0000_0000, 1'b0);
    push_key(64'shFFFF_FFFF_0000_0000, 1'b1);
    // equal children all over the heap
    push_key(64'sd7, 1'b0);
    push_key(64'sd7, 1'b0);
    push_key(64'sd2, 1'b0);
    push_key(64'sd7, 1'b0);
    push_key(64'sd7, 1'b0);
    push_key(64'sd7, 1'b1);
    // already ascending, then descending from the top
    for (i = 1; i <= 5; i++) push_key(hs_pkg::key_t'(i), i == 5);
    for (i = 0; i < 5; i++) push_key({1'b0, {63{1'b1}}} - hs_pkg::key_t'(i), i == 4);

    // full store, then a set whose closing key is dropped
    add_set(SORT_DEPTH);
    add_set(SORT_DEPTH + 1);
    random_count = pending_keys.size();
    while (random_count < RANDOM_KEYS) begin
      if ($urandom_range(0, 11) == 0) size = $urandom_range(SORT_DEPTH - 4, SORT_DEPTH + 6);
      else size = $urandom_range(1, 12);
      if (size > RANDOM_KEYS - random_count) size = RANDOM_KEYS - random_count;
      add_set(size);
      random_count += size;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_keys.size() > 0) @(posedge clk);
    while (sorted_expect.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d keys in %0d sets (%0d with dropped keys, largest %0d), %0d results checked",
             keys_taken, sets_closed, overflow_sets, largest_set, results_checked);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("heap_sorter test passed");
    end else begin
      $display("heap_sorter test failed");
    end
    $finish;
  end

endmodule
